>>> rtl/tlpd_pkg.sv
// Shared types and constants for the touch long-press dimmer core.
// No dependencies; every other file refers to this package by scoped names.
package tlpd_pkg;

    // Configuration register indexes
    localparam logic [1:0] CFG_TOUCH_THRESHOLD = 2'd0;
    localparam logic [1:0] CFG_BASELINE_COUNT  = 2'd1;
    localparam logic [1:0] CFG_LONG_PRESS_MS   = 2'd2;

    // Field and register widths
    localparam int CHARGE_W    = 9;
    localparam int THRESHOLD_W = 10;
    localparam int BASELINE_W  = 9;
    localparam int HOLD_W      = 16;
    localparam int TIME_W      = 32;
    localparam int LEVEL_W     = 8;
    localparam int CFG_DATA_W  = 16;
    localparam int SUM_W       = 11;

    // Ramp and reset constants
    localparam logic [TIME_W-1:0]  RAMP_INTERVAL_MS = 32'd35;
    localparam logic [LEVEL_W-1:0] RAMP_STEP        = 8'd5;
    localparam logic [LEVEL_W-1:0] LEVEL_TOP        = 8'd220;
    localparam logic [LEVEL_W-1:0] LEVEL_BOTTOM     = 8'd30;
    localparam logic [LEVEL_W-1:0] LEVEL_RESET      = 8'd255;
    localparam logic [HOLD_W-1:0]  LONG_PRESS_RESET = 16'd2000;

    // Press tracker results for one request
    typedef struct packed {
        logic touched;      // reading counts as a touch
        logic long_flag;    // long press held after this request
        logic ended_long;   // last ended touch was a long press
        logic long_enter;   // long press began with this request
    } t_press;

endpackage

>>> rtl/tlpd_press.sv
// Press tracker: touch detection, press start time, long-press and release flags.
// Depends on tlpd_pkg.
module tlpd_press (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_step,
    input  logic [tlpd_pkg::CHARGE_W-1:0]       i_charge_count,
    input  logic [tlpd_pkg::TIME_W-1:0]         i_now_ms,
    input  logic [tlpd_pkg::THRESHOLD_W-1:0]    i_touch_threshold,
    input  logic [tlpd_pkg::BASELINE_W-1:0]     i_baseline_count,
    input  logic [tlpd_pkg::HOLD_W-1:0]         i_long_press_ms,
    output tlpd_pkg::t_press                    o_press
);

    logic                          r_held;
    logic                          r_long;
    logic                          r_ended;
    logic [tlpd_pkg::TIME_W-1:0]   r_start;

    logic                          n_held;
    logic                          n_long;
    logic                          n_ended;
    logic [tlpd_pkg::TIME_W-1:0]   n_start;

    logic [tlpd_pkg::SUM_W-1:0]    limit;
    logic                          touched;
    logic [tlpd_pkg::TIME_W-1:0]   held_ms;
    logic                          enter;

    // Compare the reading against baseline plus margin, sum kept wide
    assign limit   = tlpd_pkg::SUM_W'(i_baseline_count) + tlpd_pkg::SUM_W'(i_touch_threshold);
    assign touched = tlpd_pkg::SUM_W'(i_charge_count) > limit;

    // Press update: start, long-press test, release
    always_comb begin
        n_held  = r_held;
        n_long  = r_long;
        n_ended = r_ended;
        n_start = r_start;
        enter   = 1'b0;
        if (touched && !r_held) begin
            n_start = i_now_ms;
            n_held  = 1'b1;
            n_long  = 1'b0;
            n_ended = 1'b0;
        end
        held_ms = i_now_ms - n_start;
        if (touched && !n_long && (held_ms >= tlpd_pkg::TIME_W'(i_long_press_ms))) begin
            n_long = 1'b1;
            enter  = 1'b1;
        end
        if (!touched && r_held) begin
            n_held  = 1'b0;
            n_ended = r_long;
            n_long  = 1'b0;
        end
    end

    assign o_press = '{touched: touched, long_flag: n_long,
                       ended_long: n_ended, long_enter: enter};

    // Hold press state between requests
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held  <= 1'b0;
            r_long  <= 1'b0;
            r_ended <= 1'b0;
            r_start <= '0;
        end else if (i_step) begin
            r_held  <= n_held;
            r_long  <= n_long;
            r_ended <= n_ended;
            r_start <= n_start;
        end
    end

endmodule

>>> rtl/tlpd_ramp.sv
// Brightness ramp: triangle level between bottom and top, one step per interval.
// Depends on tlpd_pkg.
module tlpd_ramp (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_step,
    input  logic [tlpd_pkg::TIME_W-1:0]       i_now_ms,
    input  tlpd_pkg::t_press                  i_press,
    output logic [tlpd_pkg::LEVEL_W-1:0]      o_level
);

    logic [tlpd_pkg::TIME_W-1:0]   r_last_ramp;
    logic [tlpd_pkg::LEVEL_W-1:0]  r_level;
    logic                          r_up;

    logic [tlpd_pkg::TIME_W-1:0]   n_last_ramp;
    logic [tlpd_pkg::LEVEL_W-1:0]  n_level;
    logic                          n_up;

    logic [tlpd_pkg::TIME_W-1:0]   since_ms;

    assign since_ms = i_now_ms - r_last_ramp;

    // Advance the level while a long press is held; entering restarts the interval
    always_comb begin
        n_last_ramp = r_last_ramp;
        n_level     = r_level;
        n_up        = r_up;
        if (i_press.long_enter) begin
            n_last_ramp = i_now_ms;
        end else if (i_press.long_flag && (since_ms >= tlpd_pkg::RAMP_INTERVAL_MS)) begin
            n_last_ramp = i_now_ms;
            if (r_up) begin
                if (r_level < (tlpd_pkg::LEVEL_TOP - tlpd_pkg::RAMP_STEP)) begin
                    n_level = r_level + tlpd_pkg::RAMP_STEP;
                end else begin
                    n_level = tlpd_pkg::LEVEL_TOP;
                    n_up    = 1'b0;
                end
            end else begin
                if (r_level > (tlpd_pkg::LEVEL_BOTTOM + tlpd_pkg::RAMP_STEP)) begin
                    n_level = r_level - tlpd_pkg::RAMP_STEP;
                end else begin
                    n_level = tlpd_pkg::LEVEL_BOTTOM;
                    n_up    = 1'b1;
                end
            end
        end
    end

    assign o_level = n_level;

    // Hold ramp state between requests
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_ramp <= '0;
            r_level     <= tlpd_pkg::LEVEL_RESET;
            r_up        <= 1'b1;
        end else if (i_step) begin
            r_last_ramp <= n_last_ramp;
            r_level     <= n_level;
            r_up        <= n_up;
        end
    end

endmodule

>>> rtl/touch_long_press_dimmer_core.sv
// Top level of the touch long-press dimmer: handshakes, configuration, registers.
// Depends on tlpd_pkg, tlpd_press and tlpd_ramp.
//
// Takes one touch reading with its millisecond timestamp per request and returns
// one result per request: touch, long-press, last-release and brightness. A
// request is registered on entry, then processed by the press tracker and
// brightness ramp, and its result lands in the output register. A new request
// is accepted every cycle unless the result channel stalls with both registers
// full. The state loop (press flags, timestamps, level) closes through a 32-bit
// subtract and compare. Configuration writes take effect at once; the user must
// make them only while no request is in flight, the block does not enforce it.
module touch_long_press_dimmer_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // configuration write port
    input  logic                                i_cfg_we,
    input  logic [1:0]                          i_cfg_index,
    input  logic [tlpd_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    // request channel
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [tlpd_pkg::CHARGE_W-1:0]       i_charge_count,
    input  logic [tlpd_pkg::TIME_W-1:0]         i_now_ms,
    // result channel
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic                                o_touched,
    output logic                                o_long_press_active,
    output logic                                o_last_was_long,
    output logic [tlpd_pkg::LEVEL_W-1:0]        o_brightness
);

    logic [tlpd_pkg::THRESHOLD_W-1:0]  r_touch_threshold;
    logic [tlpd_pkg::BASELINE_W-1:0]   r_baseline_count;
    logic [tlpd_pkg::HOLD_W-1:0]       r_long_press_ms;

    logic                              r_in_valid;
    logic [tlpd_pkg::CHARGE_W-1:0]     r_charge_count;
    logic [tlpd_pkg::TIME_W-1:0]       r_now_ms;

    logic                              r_out_valid;
    logic                              r_touched;
    logic                              r_long;
    logic                              r_ended;
    logic [tlpd_pkg::LEVEL_W-1:0]      r_level;

    logic                              advance;
    logic                              step;
    logic                              in_take;
    tlpd_pkg::t_press                  press;
    logic [tlpd_pkg::LEVEL_W-1:0]      level_next;

    // Pipeline moves when the result register is empty or being drained
    assign advance    = !r_out_valid || !i_out_stall;
    assign step       = r_in_valid && advance;
    assign o_in_stall = r_in_valid && !advance;
    assign in_take    = i_in_valid && !o_in_stall;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_touch_threshold <= '0;
            r_baseline_count  <= '0;
            r_long_press_ms   <= tlpd_pkg::LONG_PRESS_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                tlpd_pkg::CFG_TOUCH_THRESHOLD: begin
                    r_touch_threshold <= i_cfg_data[tlpd_pkg::THRESHOLD_W-1:0];
                end
                tlpd_pkg::CFG_BASELINE_COUNT: begin
                    r_baseline_count <= i_cfg_data[tlpd_pkg::BASELINE_W-1:0];
                end
                tlpd_pkg::CFG_LONG_PRESS_MS: begin
                    r_long_press_ms <= i_cfg_data[tlpd_pkg::HOLD_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // Input register: capture a request, drop valid once it moves on
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (step) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_charge_count <= i_charge_count;
            r_now_ms       <= i_now_ms;
        end
    end

    tlpd_press u_press (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_step            (step),
        .i_charge_count    (r_charge_count),
        .i_now_ms          (r_now_ms),
        .i_touch_threshold (r_touch_threshold),
        .i_baseline_count  (r_baseline_count),
        .i_long_press_ms   (r_long_press_ms),
        .o_press           (press)
    );

    tlpd_ramp u_ramp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .i_now_ms (r_now_ms),
        .i_press  (press),
        .o_level  (level_next)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_touched <= press.touched;
            r_long    <= press.long_flag;
            r_ended   <= press.ended_long;
            r_level   <= level_next;
        end
    end

    assign o_out_valid         = r_out_valid;
    assign o_touched           = r_touched;
    assign o_long_press_active = r_long;
    assign o_last_was_long     = r_ended;
    assign o_brightness        = r_level;

endmodule
